### hdl/mspdf_pkg.sv
// Shared types and constants of the serial protocol deframer.
package mspdf_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 6;
  localparam int IDX_W           = 5;
  localparam int CFG_W           = 6;
  localparam int FIFO_DEPTH      = 4;
  // distance of the first payload byte from the frame's start byte
  localparam int PAYLOAD_OFS     = 5;

  localparam logic [CFG_W-1:0]  LEN_RESET  = 6'd32;
  localparam logic [BYTE_W-1:0] SYNC_START = 8'h24;  // '$'
  localparam logic [BYTE_W-1:0] SYNC_PROTO = 8'h4D;  // 'M'

  typedef enum logic [2:0] {
    PH_START,
    PH_PROTO,
    PH_DIR,
    PH_LEN,
    PH_CODE,
    PH_DATA,
    PH_SUM
  } hunt_phase_t;

  typedef enum logic [1:0] {
    FR_RUN,
    FR_FETCH,
    FR_SCAN
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } bk_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] dir;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] sum;
  } frame_hdr_t;

endpackage

### hdl/mspdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mspdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/mspdf_fifo.sv
// Short register queue of found frames between hunt engine and result emitter.
module mspdf_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold entry contents
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = mem[rd_ptr_r];
  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);

endmodule

### hdl/mspdf_front.sv
// Hunt engine: stores received bytes, finds frames, rescans rejected frames.
module mspdf_front
  import mspdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int PTR_W       = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_W-1:0]  max_len,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              ram_wr_en,
  output logic [PTR_W-1:0]  ram_wr_addr,
  output logic [BYTE_W-1:0] ram_wr_data,
  output logic [PTR_W-1:0]  ram_rd_addr,
  input  logic [BYTE_W-1:0] ram_rd_data,
  output logic              q_push,
  output frame_hdr_t        q_hdr,
  output logic [PTR_W-1:0]  q_base,
  input  logic              q_full,
  input  logic              q_empty,
  input  logic [PTR_W-1:0]  q_head_base
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  fr_state_t         state_r, state_nxt;
  hunt_phase_t       phase_r, phase_nxt;
  logic [BYTE_W-1:0] dir_r, dir_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0] code_r, code_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  base_r, base_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;

  logic              room;
  logic              in_fire;
  logic              step;
  logic [BYTE_W-1:0] cur_byte;
  logic [PTR_W-1:0]  cur_pos;
  logic              reject;
  logic              emit;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  cnt_inc;
  logic              scan_done;

  // keep the oldest queued frame's bytes safe from new writes
  assign room = q_empty || ((wr_ptr_r - q_head_base) != {PTR_W{1'b1}});

  assign limit     = (max_len < MAX_LEN) ? max_len : MAX_LEN;
  assign cnt_inc   = cnt_r + 1'b1;
  assign scan_done = ((rd_ptr_r + 1'b1) == wr_ptr_r);

  // select byte source by state
  always_comb begin
    in_ready = 1'b0;
    step     = 1'b0;
    cur_byte = in_rx_byte;
    cur_pos  = wr_ptr_r;
    unique case (state_r)
      FR_RUN: begin
        in_ready = !q_full && room;
        step     = in_valid && !q_full && room;
      end
      FR_FETCH: begin
        step = 1'b0;
      end
      FR_SCAN: begin
        step     = !q_full;
        cur_byte = ram_rd_data;
        cur_pos  = rd_ptr_r;
      end
      default: begin
        step = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_RUN: begin
        if (step && reject) begin
          state_nxt = FR_FETCH;
        end
      end
      FR_FETCH: begin
        state_nxt = FR_SCAN;
      end
      FR_SCAN: begin
        if (step) begin
          if (reject || !scan_done) begin
            state_nxt = FR_FETCH;
          end else begin
            state_nxt = FR_RUN;
          end
        end
      end
      default: begin
        state_nxt = FR_RUN;
      end
    endcase
  end

  // run one byte through the hunt
  always_comb begin
    phase_nxt = phase_r;
    dir_nxt   = dir_r;
    len_nxt   = len_r;
    code_nxt  = code_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    reject    = 1'b0;
    emit      = 1'b0;
    if (step) begin
      unique case (phase_r)
        PH_START: begin
          if (cur_byte == SYNC_START) begin
            base_nxt  = cur_pos;
            phase_nxt = PH_PROTO;
          end
        end
        PH_PROTO: begin
          if (cur_byte == SYNC_PROTO) begin
            phase_nxt = PH_DIR;
          end else if (cur_byte == SYNC_START) begin
            base_nxt  = cur_pos;
            phase_nxt = PH_PROTO;
          end else begin
            phase_nxt = PH_START;
          end
        end
        PH_DIR: begin
          dir_nxt   = cur_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (cur_byte > BYTE_W'(limit)) begin
            reject    = 1'b1;
            phase_nxt = PH_START;
          end else begin
            len_nxt   = cur_byte[LEN_W-1:0];
            sum_nxt   = cur_byte;
            cnt_nxt   = '0;
            phase_nxt = PH_CODE;
          end
        end
        PH_CODE: begin
          code_nxt  = cur_byte;
          sum_nxt   = sum_r ^ cur_byte;
          phase_nxt = (len_r != '0) ? PH_DATA : PH_SUM;
        end
        PH_DATA: begin
          sum_nxt = sum_r ^ cur_byte;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_nxt = PH_START;
          if (cur_byte == sum_r) begin
            emit = 1'b1;
          end else begin
            reject = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end
  end

  // advance store pointers; a reject rewinds the read pointer past the start byte
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (step && reject) begin
      rd_ptr_nxt = base_r + 1'b1;
    end else if (step && (state_r == FR_SCAN)) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FR_RUN;
      phase_r  <= PH_START;
      dir_r    <= '0;
      len_r    <= '0;
      code_r   <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      base_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      dir_r    <= dir_nxt;
      len_r    <= len_nxt;
      code_r   <= code_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      base_r   <= base_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  assign ram_wr_en   = in_fire;
  assign ram_wr_addr = wr_ptr_r;
  assign ram_wr_data = in_rx_byte;
  assign ram_rd_addr = rd_ptr_r;

  assign q_push   = emit;
  assign q_hdr    = '{dir: dir_r, len: len_r, code: code_r, sum: sum_r};
  assign q_base   = base_r;

endmodule

### hdl/mspdf_back.sv
// Result emitter: walks each queued frame's payload and fills the output register.
module mspdf_back
  import mspdf_pkg::*;
#(
  parameter int PTR_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  frame_hdr_t        q_hdr,
  input  logic [PTR_W-1:0]  q_base,
  output logic              q_pop,
  output logic [PTR_W-1:0]  ram_rd_addr,
  input  logic [BYTE_W-1:0] ram_rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_frame_direction,
  output logic [LEN_W-1:0]  out_frame_length,
  output logic [BYTE_W-1:0] out_frame_code,
  output logic [BYTE_W-1:0] out_frame_checksum,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic [IDX_W-1:0]  out_payload_index,
  output logic              out_has_payload,
  output logic              out_last_of_frame
);

  bk_state_t         state_r, state_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] dir_r, len_dummy_unused;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] code_r, sum_r, byte_r;
  logic [IDX_W-1:0]  idx_r;
  logic              has_r, last_r;

  logic              has_pl;
  logic              is_last;
  logic              load;

  assign has_pl  = (q_hdr.len != '0);
  assign is_last = !has_pl || ((k_r + 1'b1) == q_hdr.len);

  assign ram_rd_addr = q_base + PTR_W'(PAYLOAD_OFS) + PTR_W'(k_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_SEND;
      end
      BK_SEND: begin
        if (load) begin
          state_nxt = is_last ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // load the output register when it is free
  always_comb begin
    load = 1'b0;
    unique case (state_r)
      BK_IDLE:  load = 1'b0;
      BK_READ:  load = 1'b0;
      BK_SEND:  load = !out_valid_r || out_ready;
      default:  load = 1'b0;
    endcase
  end

  assign q_pop = load && is_last;

  // step through payload positions and hold the output beat
  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      k_nxt         = is_last ? '0 : k_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dir_r  <= q_hdr.dir;
      len_r  <= q_hdr.len;
      code_r <= q_hdr.code;
      sum_r  <= q_hdr.sum;
      byte_r <= has_pl ? ram_rd_data : '0;
      idx_r  <= has_pl ? k_r[IDX_W-1:0] : '0;
      has_r  <= has_pl;
      last_r <= is_last;
    end
  end

  assign len_dummy_unused    = '0;
  assign out_valid           = out_valid_r;
  assign out_frame_direction = dir_r | len_dummy_unused;
  assign out_frame_length    = len_r;
  assign out_frame_code      = code_r;
  assign out_frame_checksum  = sum_r;
  assign out_payload_byte    = byte_r;
  assign out_payload_index   = idx_r;
  assign out_has_payload     = has_r;
  assign out_last_of_frame   = last_r;

endmodule

### hdl/msp_frame_deframer_top.sv
// Serial protocol frame deframer: ring store, hunt engine, frame queue, result emitter.
// Throughput: one received byte per cycle while hunting, unless the frame queue is full
//   or the ring lacks room; a rejected frame is rescanned from the byte ring, each stored
//   byte via fetch and scan states, with input held off. Each result passes the emitter's
//   read and send states (registered emit ring read), output register backpressure aside.
// Reset: synchronous, active low; control state cleared, limit 32, ring left uncleared.
module msp_frame_deframer_top
  import mspdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_frame_direction,
  output logic [LEN_W-1:0]  out_frame_length,
  output logic [BYTE_W-1:0] out_frame_code,
  output logic [BYTE_W-1:0] out_frame_checksum,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic [IDX_W-1:0]  out_payload_index,
  output logic              out_has_payload,
  output logic              out_last_of_frame
);

  // ring holds a frame in flight plus queued frames awaiting emission
  localparam int RING_DEPTH = 2 ** $clog2(2 * (MAX_PAYLOAD + 6));
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int HDR_W      = $bits(frame_hdr_t);
  localparam int Q_W        = HDR_W + PTR_W;

  logic [CFG_W-1:0]  max_len_r, max_len_nxt;

  logic              ram_wr_en;
  logic [PTR_W-1:0]  ram_wr_addr;
  logic [BYTE_W-1:0] ram_wr_data;
  logic [PTR_W-1:0]  scan_rd_addr, emit_rd_addr;
  logic [BYTE_W-1:0] scan_rd_data, emit_rd_data;

  logic              q_push, q_pop, q_full, q_empty;
  frame_hdr_t        q_push_hdr, q_head_hdr;
  logic [PTR_W-1:0]  q_push_base, q_head_base;
  logic [Q_W-1:0]    q_head_data;

  // write the limit register
  always_comb begin
    max_len_nxt = max_len_r;
    if (cfg_wr_en) begin
      max_len_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  mspdf_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .PTR_W       (PTR_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_len     (max_len_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (scan_rd_addr),
    .ram_rd_data (scan_rd_data),
    .q_push      (q_push),
    .q_hdr       (q_push_hdr),
    .q_base      (q_push_base),
    .q_full      (q_full),
    .q_empty     (q_empty),
    .q_head_base (q_head_base)
  );

  // ring copy read by the rescan path
  mspdf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_scan_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (scan_rd_addr),
    .rd_data (scan_rd_data)
  );

  // ring copy read by the emit path
  mspdf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_emit_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (emit_rd_addr),
    .rd_data (emit_rd_data)
  );

  mspdf_fifo #(
    .WIDTH (Q_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({q_push_hdr, q_push_base}),
    .pop       (q_pop),
    .head_data (q_head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign q_head_hdr  = frame_hdr_t'(q_head_data[Q_W-1:PTR_W]);
  assign q_head_base = q_head_data[PTR_W-1:0];

  mspdf_back #(
    .PTR_W (PTR_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_hdr               (q_head_hdr),
    .q_base              (q_head_base),
    .q_pop               (q_pop),
    .ram_rd_addr         (emit_rd_addr),
    .ram_rd_data         (emit_rd_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_direction (out_frame_direction),
    .out_frame_length    (out_frame_length),
    .out_frame_code      (out_frame_code),
    .out_frame_checksum  (out_frame_checksum),
    .out_payload_byte    (out_payload_byte),
    .out_payload_index   (out_payload_index),
    .out_has_payload     (out_has_payload),
    .out_last_of_frame   (out_last_of_frame)
  );

endmodule
